### src/bug0_pkg.sv
`default_nettype none

package bug0_pkg;

    // Field widths
    localparam int DistW    = 12;
    localparam int HeadW    = 9;
    localparam int GoalW    = 10;
    localparam int TolW     = 8;
    localparam int CruiseW  = 7;
    localparam int SpeedW   = 8;
    localparam int EventW   = 3;
    localparam int ErrW     = 11;   // heading error, signed, covers -663..511

    // Configuration bus
    localparam int ApbAddrW = 5;
    localparam int ApbDataW = 32;

    // Degrees
    localparam logic [GoalW-1:0]      FullTurn = GoalW'(360);
    localparam logic signed [ErrW-1:0] HalfTurn = ErrW'(180);

    // Fixed wheel commands
    localparam logic signed [SpeedW-1:0] SpdZero       = SpeedW'(0);
    localparam logic signed [SpeedW-1:0] SpdTurnLeftL  = -SpeedW'(6);
    localparam logic signed [SpeedW-1:0] SpdTurnLeftR  = SpeedW'(7);
    localparam logic signed [SpeedW-1:0] SpdTurnRightL = SpeedW'(8);
    localparam logic signed [SpeedW-1:0] SpdTurnRightR = -SpeedW'(7);
    localparam logic signed [SpeedW-1:0] SpdEscRightR  = SpeedW'(15);
    localparam logic signed [SpeedW-1:0] SpdEscLeftL   = SpeedW'(16);
    localparam logic signed [SpeedW-1:0] SpdAvoidL     = -SpeedW'(11);
    localparam logic signed [SpeedW-1:0] SpdAvoidR     = SpeedW'(12);

    // Event codes
    typedef enum logic [EventW-1:0] {
        EV_GOAL       = 3'd0,
        EV_ENTER      = 3'd1,
        EV_END        = 3'd2,
        EV_FWD        = 3'd3,
        EV_AVOID_TURN = 3'd4,
        EV_ESCAPE     = 3'd5,
        EV_NONE       = 3'd6
    } t_event;

    // Register indexes (byte address / 4)
    typedef enum logic [2:0] {
        REG_GOAL_HEADING      = 3'd0,
        REG_SIDE_CRASH_LIMIT  = 3'd1,
        REG_FRONT_LIMIT       = 3'd2,
        REG_SIDE_CLEAR_LIMIT  = 3'd3,
        REG_TURN_SIDE_LIMIT   = 3'd4,
        REG_HEADING_TOLERANCE = 3'd5,
        REG_CRUISE_SPEED      = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [GoalW-1:0]   goal_heading;
        logic [DistW-1:0]   side_crash_limit;
        logic [DistW-1:0]   front_limit;
        logic [DistW-1:0]   side_clear_limit;
        logic [DistW-1:0]   turn_side_limit;
        logic [TolW-1:0]    heading_tolerance;
        logic [CruiseW-1:0] cruise_speed;
    } t_cfg;

    typedef struct packed {
        logic [DistW-1:0] front_distance;
        logic [DistW-1:0] right_distance;
        logic [DistW-1:0] left_distance;
        logic [HeadW-1:0] heading;
        logic             run_enable;
    } t_item;

    typedef struct packed {
        logic                     avoiding;
        logic                     turning;
        logic signed [SpeedW-1:0] left_drive;
        logic signed [SpeedW-1:0] right_drive;
    } t_state;

    typedef struct packed {
        logic signed [SpeedW-1:0] left_speed;
        logic signed [SpeedW-1:0] right_speed;
        t_event                   event_code;
        logic                     avoid_mode;
        logic                     turn_mode;
    } t_result;

endpackage

`default_nettype wire

### src/bug0_cfg_regs.sv
`default_nettype none

module bug0_cfg_regs (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [bug0_pkg::ApbAddrW-1:0]  paddr,
    input  wire logic [bug0_pkg::ApbDataW-1:0]  pwdata,
    output logic      [bug0_pkg::ApbDataW-1:0]  prdata,
    output logic                                pready,
    output bug0_pkg::t_cfg                      o_cfg
);

    bug0_pkg::t_cfg   r_cfg;
    bug0_pkg::t_reg_idx w_idx;
    logic             w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;
    assign w_idx  = bug0_pkg::t_reg_idx'(paddr[4:2]);
    assign o_cfg  = r_cfg;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                bug0_pkg::REG_GOAL_HEADING:
                    r_cfg.goal_heading <= pwdata[bug0_pkg::GoalW-1:0];
                bug0_pkg::REG_SIDE_CRASH_LIMIT:
                    r_cfg.side_crash_limit <= pwdata[bug0_pkg::DistW-1:0];
                bug0_pkg::REG_FRONT_LIMIT:
                    r_cfg.front_limit <= pwdata[bug0_pkg::DistW-1:0];
                bug0_pkg::REG_SIDE_CLEAR_LIMIT:
                    r_cfg.side_clear_limit <= pwdata[bug0_pkg::DistW-1:0];
                bug0_pkg::REG_TURN_SIDE_LIMIT:
                    r_cfg.turn_side_limit <= pwdata[bug0_pkg::DistW-1:0];
                bug0_pkg::REG_HEADING_TOLERANCE:
                    r_cfg.heading_tolerance <= pwdata[bug0_pkg::TolW-1:0];
                bug0_pkg::REG_CRUISE_SPEED:
                    r_cfg.cruise_speed <= pwdata[bug0_pkg::CruiseW-1:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        prdata = '0;
        unique case (w_idx)
            bug0_pkg::REG_GOAL_HEADING:
                prdata = bug0_pkg::ApbDataW'(r_cfg.goal_heading);
            bug0_pkg::REG_SIDE_CRASH_LIMIT:
                prdata = bug0_pkg::ApbDataW'(r_cfg.side_crash_limit);
            bug0_pkg::REG_FRONT_LIMIT:
                prdata = bug0_pkg::ApbDataW'(r_cfg.front_limit);
            bug0_pkg::REG_SIDE_CLEAR_LIMIT:
                prdata = bug0_pkg::ApbDataW'(r_cfg.side_clear_limit);
            bug0_pkg::REG_TURN_SIDE_LIMIT:
                prdata = bug0_pkg::ApbDataW'(r_cfg.turn_side_limit);
            bug0_pkg::REG_HEADING_TOLERANCE:
                prdata = bug0_pkg::ApbDataW'(r_cfg.heading_tolerance);
            bug0_pkg::REG_CRUISE_SPEED:
                prdata = bug0_pkg::ApbDataW'(r_cfg.cruise_speed);
            default:
                prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

### src/bug0_step.sv
`default_nettype none

module bug0_step (
    input  bug0_pkg::t_cfg    i_cfg,
    input  bug0_pkg::t_item   i_item,
    input  bug0_pkg::t_state  i_state,
    output bug0_pkg::t_state  o_state,
    output bug0_pkg::t_result o_result
);

    logic [bug0_pkg::GoalW-1:0]          w_goal;
    logic signed [bug0_pkg::ErrW-1:0]    w_err;
    logic signed [bug0_pkg::ErrW-1:0]    w_tol;
    logic signed [bug0_pkg::ErrW-1:0]    w_ntol;
    logic signed [bug0_pkg::SpeedW-1:0]  w_cruise;
    logic                                w_on_strict;
    logic                                w_on_incl;
    logic                                w_turn_left;
    logic                                w_right_crash;
    logic                                w_left_crash;
    bug0_pkg::t_state                    n_st;
    bug0_pkg::t_event                    n_ev;

    // Goal bearing folded once into range, then signed heading error
    assign w_goal   = (i_cfg.goal_heading > bug0_pkg::FullTurn) ?
                      (i_cfg.goal_heading - bug0_pkg::FullTurn) : i_cfg.goal_heading;
    assign w_err    = $signed({2'b00, i_item.heading}) - $signed({1'b0, w_goal});
    assign w_tol    = $signed({3'b000, i_cfg.heading_tolerance});
    assign w_ntol   = -w_tol;
    assign w_cruise = $signed({1'b0, i_cfg.cruise_speed});

    assign w_on_strict = (w_err < w_tol) && (w_err > w_ntol);
    assign w_on_incl   = (w_err <= w_tol) && (w_err >= w_ntol);
    assign w_turn_left = (w_err > bug0_pkg::HalfTurn) ||
                         ((w_err <= $signed(bug0_pkg::ErrW'(0))) &&
                          (w_err > -bug0_pkg::HalfTurn));

    assign w_right_crash = i_item.right_distance < i_cfg.side_crash_limit;
    assign w_left_crash  = i_item.left_distance < i_cfg.side_crash_limit;

    always_comb begin
        n_st = i_state;
        n_ev = bug0_pkg::EV_NONE;
        if (i_state.turning || (!i_state.avoiding && !w_right_crash && !w_left_crash &&
                (i_item.front_distance > i_cfg.front_limit) && !w_on_incl)) begin
            // One turn iteration (also the first one when turning starts)
            n_st.turning = 1'b1;
            if (!i_item.run_enable) begin
                n_st.left_drive  = bug0_pkg::SpdZero;
                n_st.right_drive = bug0_pkg::SpdZero;
                n_st.turning     = 1'b0;
            end else if (w_on_strict) begin
                n_st.turning     = 1'b0;
                n_st.left_drive  = w_cruise;
                n_st.right_drive = w_cruise;
                n_ev             = bug0_pkg::EV_GOAL;
            end else if (i_item.right_distance < i_cfg.turn_side_limit) begin
                n_st.left_drive  = bug0_pkg::SpdZero;
                n_st.right_drive = bug0_pkg::SpdZero;
                n_st.turning     = 1'b0;
                n_st.avoiding    = 1'b1;
                n_ev             = bug0_pkg::EV_ENTER;
            end else if (w_turn_left) begin
                n_st.left_drive  = bug0_pkg::SpdTurnLeftL;
                n_st.right_drive = bug0_pkg::SpdTurnLeftR;
            end else begin
                n_st.left_drive  = bug0_pkg::SpdTurnRightL;
                n_st.right_drive = bug0_pkg::SpdTurnRightR;
            end
        end else if (w_right_crash) begin
            n_st.left_drive  = bug0_pkg::SpdZero;
            n_st.right_drive = bug0_pkg::SpdEscRightR;
            n_ev             = bug0_pkg::EV_ESCAPE;
        end else if (w_left_crash) begin
            n_st.left_drive  = bug0_pkg::SpdEscLeftL;
            n_st.right_drive = bug0_pkg::SpdZero;
            n_ev             = bug0_pkg::EV_ESCAPE;
        end else if (i_state.avoiding) begin
            // Wall following rules
            if (i_item.front_distance < i_cfg.front_limit) begin
                n_st.left_drive  = bug0_pkg::SpdAvoidL;
                n_st.right_drive = bug0_pkg::SpdAvoidR;
                n_ev             = bug0_pkg::EV_AVOID_TURN;
            end else if (i_item.right_distance > i_cfg.side_clear_limit) begin
                n_st.avoiding = 1'b0;
                n_ev          = bug0_pkg::EV_END;
            end else if ((i_item.right_distance > i_cfg.side_crash_limit) &&
                         (i_item.left_distance > i_cfg.side_crash_limit)) begin
                n_st.left_drive  = w_cruise;
                n_st.right_drive = w_cruise;
                n_ev             = bug0_pkg::EV_FWD;
            end
        end else if (i_item.front_distance > i_cfg.front_limit) begin
            // On course toward goal
            n_st.left_drive  = w_cruise;
            n_st.right_drive = w_cruise;
            n_ev             = bug0_pkg::EV_GOAL;
        end else begin
            n_st.left_drive  = bug0_pkg::SpdZero;
            n_st.right_drive = bug0_pkg::SpdZero;
            n_st.avoiding    = 1'b1;
        end
    end

    assign o_state              = n_st;
    assign o_result.left_speed  = n_st.left_drive;
    assign o_result.right_speed = n_st.right_drive;
    assign o_result.event_code  = n_ev;
    assign o_result.avoid_mode  = n_st.avoiding;
    assign o_result.turn_mode   = n_st.turning;

endmodule

`default_nettype wire

### src/bug0_navigation_controller.sv
// Path: a request accepted into the input register, then its result held in the result register.
// Throughput: one request per cycle; while a finished result waits on m_axis_tready the
// input register can still take one request, after that s_axis_tready drops.
// Reset: i_rst_n synchronous active low; clears stage valids, modes, held wheel speeds
// and all configuration registers.
`default_nettype none

module bug0_navigation_controller (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // Request stream
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // [11:0] front_distance, [23:12] right_distance, [35:24] left_distance,
    // [44:36] heading, [47:45] zero
    input  wire logic [47:0]                   s_axis_tdata,
    // [0] run_enable
    input  wire logic                          s_axis_tuser,
    // Result stream
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // [7:0] left_speed, [15:8] right_speed
    output logic [15:0]                        m_axis_tdata,
    // [2:0] event_code, [3] avoid_mode, [4] turn_mode
    output logic [4:0]                         m_axis_tuser,
    // Configuration
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [bug0_pkg::ApbAddrW-1:0] paddr,
    input  wire logic [bug0_pkg::ApbDataW-1:0] pwdata,
    output logic      [bug0_pkg::ApbDataW-1:0] prdata,
    output logic                               pready
);

    bug0_pkg::t_cfg    w_cfg;
    bug0_pkg::t_item   r_item;
    logic              r_in_valid;
    bug0_pkg::t_state  r_state;
    bug0_pkg::t_state  n_state;
    bug0_pkg::t_result n_result;
    bug0_pkg::t_result r_result;
    logic              r_out_valid;
    logic              w_out_ready;
    logic              w_adv;

    bug0_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    bug0_step u_step (
        .i_cfg    (w_cfg),
        .i_item   (r_item),
        .i_state  (r_state),
        .o_state  (n_state),
        .o_result (n_result)
    );

    // Stage handshakes
    assign w_out_ready   = !r_out_valid || m_axis_tready;
    assign w_adv         = r_in_valid && w_out_ready;
    assign s_axis_tready = !r_in_valid || w_out_ready;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
        if (s_axis_tready && s_axis_tvalid) begin
            r_item.front_distance <= s_axis_tdata[11:0];
            r_item.right_distance <= s_axis_tdata[23:12];
            r_item.left_distance  <= s_axis_tdata[35:24];
            r_item.heading        <= s_axis_tdata[44:36];
            r_item.run_enable     <= s_axis_tuser;
        end
    end

    // Controller state, updated once per processed request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (w_adv) begin
            r_state <= n_state;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_ready) begin
            r_out_valid <= r_in_valid;
        end
        if (w_adv) begin
            r_result <= n_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_result.right_speed, r_result.left_speed};
    assign m_axis_tuser  = {r_result.turn_mode, r_result.avoid_mode, r_result.event_code};

endmodule

`default_nettype wire

### src/bug0_checker.sv
`default_nettype none

module bug0_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [15:0] m_axis_tdata,
    input wire logic [4:0]  m_axis_tuser,
    input wire logic        pready
);

    // No result appears in the cycle right after reset
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // A stalled result holds its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // Turning starts only outside avoidance, and the two modes are never set together
    a_modes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[3] && m_axis_tuser[4]))
        else $error("avoid and turn modes both set");

    // Goal forward leaves both modes clear and both wheels equal
    a_goal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser[2:0] == 3'd0) |->
            !m_axis_tuser[3] && !m_axis_tuser[4] && (m_axis_tdata[7:0] == m_axis_tdata[15:8]))
        else $error("goal event with inconsistent modes or speeds");

    // Config port never waits, and no valid result carries the reserved event code 7
    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready && (m_axis_tuser[2:0] != 3'd7 || !m_axis_tvalid))
        else $error("pready low or reserved event code");

endmodule

bind bug0_navigation_controller bug0_checker u_bug0_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .pready        (pready)
);

`default_nettype wire
